/* hw/rtl/lett_pkg.sv */
// Shared constants for the looping elapsed-time tracker.
package lett_pkg;

  // Widths of the fixed request fields.
  localparam int FUNC_BITS  = 3;
  localparam int VALUE_BITS = 32;

  // Command codes carried in the func field.
  localparam logic [FUNC_BITS-1:0] FUNC_ADVANCE  = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SET_TIME = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_SET_PROG = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_START    = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_STOP     = 3'd4;
  localparam logic [FUNC_BITS-1:0] FUNC_RESUME   = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE = 2'd2;

endpackage

/* hw/rtl/lett_if.sv */
// Request and result channel interfaces of the elapsed-time tracker.
interface lett_in_if import lett_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [FUNC_BITS-1:0]         func;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface lett_out_if #(
  parameter int TIME_BITS = 31,
  parameter int FRAC_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] elapsed_out;
  logic [FRAC_BITS:0]   progress_out;
  logic                 running_out;
  logic                 stopped_now;

  modport source (output valid, output elapsed_out, output progress_out,
                  output running_out, output stopped_now, input ready);
  modport sink   (input valid, input elapsed_out, input progress_out,
                  input running_out, input stopped_now, output ready);
endinterface

/* hw/rtl/looping_elapsed_time_tracker.sv */
// Top level of the looping elapsed-time tracker with its bit-serial divider.
//
//   Channel  Direction  Handshake      Contents
//   in_if    sink       valid/ready    func, value
//   out_if   source     valid/ready    elapsed_out, progress_out, running_out,
//                                      stopped_now
//   cfg_*    sink       cfg_we         cfg_index, cfg_wdata
//
// One request is worked on at a time; a result waits in the output register
// while the next request is taken. Set progress adds a serial multiply and a
// time that wraps a serial remainder, MAG_BITS = max(TIME_BITS, 31) + 2.
// The wrap remainder and the progress division share one restoring
// compare-subtract step. Reset is synchronous.
// A stalled result holds the block in its final state until taken.
module looping_elapsed_time_tracker import lett_pkg::*; #(
  parameter int TIME_BITS = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  lett_in_if.sink                 in_if,
  lett_out_if.source              out_if,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]    cfg_wdata
);

  // Magnitude bits of any new time, and its signed width.
  localparam int MAG_BITS = ((TIME_BITS > 31) ? TIME_BITS : 31) + 2;
  localparam int T_BITS   = MAG_BITS + 1;
  localparam int MAXIT    = (MAG_BITS > FRAC_BITS) ? MAG_BITS : FRAC_BITS;
  localparam int CNT_BITS = $clog2(MAXIT);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_FIT  = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_WRAP = 4'd5;
  localparam logic [3:0] S_PROG = 4'd6;
  localparam logic [3:0] S_PDIV = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // Whole-length multiple of a set-progress request, clamped to -1..2.
  localparam logic [1:0] Q_MINUS = 2'd0;
  localparam logic [1:0] Q_ZERO  = 2'd1;
  localparam logic [1:0] Q_ONE   = 2'd2;
  localparam logic [1:0] Q_TWO   = 2'd3;

  logic [TIME_BITS-1:0]     len_r;
  logic                     loop_r;
  logic                     rev_r;
  logic [TIME_BITS-1:0]     elapsed_r, elapsed_nxt;
  logic                     running_r, running_nxt;
  logic                     stop_r, stop_nxt;
  logic [3:0]               state_r, state_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic signed [T_BITS-1:0] t_r, t_nxt;
  logic [TIME_BITS-1:0]     acc_r, acc_nxt;
  logic [FRAC_BITS-1:0]     rsh_r, rsh_nxt;
  logic [1:0]               qsel_r, qsel_nxt;
  logic [MAG_BITS-1:0]      mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [TIME_BITS-1:0]     rem_r, rem_nxt;
  logic [FRAC_BITS:0]       prog_r, prog_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [TIME_BITS-1:0]     out_elapsed_r, out_elapsed_nxt;
  logic [FRAC_BITS:0]       out_prog_r, out_prog_nxt;
  logic                     out_run_r, out_run_nxt;
  logic                     out_stop_r, out_stop_nxt;

  // Combinational helpers.
  logic                     in_fire;
  logic signed [T_BITS-1:0] len_w, elapsed_w, value_w, acc_w, base_w, neg_t;
  logic signed [VALUE_BITS-1:0] q_full;
  logic [TIME_BITS:0]       mul_sum;
  logic [TIME_BITS:0]       div_rem2, div_diff;
  logic                     div_ge, div_bit;
  logic                     len_zero;

  assign in_if.ready      = (state_r == S_IDLE);
  assign in_fire          = in_if.valid && (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.elapsed_out  = out_elapsed_r;
  assign out_if.progress_out = out_prog_r;
  assign out_if.running_out  = out_run_r;
  assign out_if.stopped_now  = out_stop_r;

  // Sign and zero extensions to the working time width.
  assign len_w     = $signed({{(T_BITS-TIME_BITS){1'b0}}, len_r});
  assign elapsed_w = $signed({{(T_BITS-TIME_BITS){1'b0}}, elapsed_r});
  assign value_w   = $signed({{(T_BITS-VALUE_BITS){in_if.value[VALUE_BITS-1]}},
                              in_if.value});
  assign acc_w     = $signed({{(T_BITS-TIME_BITS){1'b0}}, acc_r});
  assign neg_t     = -t_r;
  assign q_full    = in_if.value >>> FRAC_BITS;
  assign len_zero  = (len_r == '0);

  // Whole-length part of the set-progress time.
  always_comb begin
    case (qsel_r)
      Q_MINUS: base_w = -len_w;
      Q_ONE:   base_w = len_w;
      Q_TWO:   base_w = len_w <<< 1;
      default: base_w = '0;
    endcase
  end

  // Serial multiply step: add the length under the current fraction bit, halve.
  assign mul_sum = {1'b0, acc_r} + (rsh_r[0] ? {1'b0, len_r} : '0);

  // Shared restoring divider step for both the wrap remainder and progress.
  assign div_bit  = (state_r == S_MOD) ? mag_r[MAG_BITS-1] : 1'b0;
  assign div_rem2 = {rem_r, div_bit};
  assign div_ge   = (div_rem2 >= {1'b0, len_r});
  assign div_diff = div_rem2 - {1'b0, len_r};

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    elapsed_nxt     = elapsed_r;
    running_nxt     = running_r;
    stop_nxt        = stop_r;
    t_nxt           = t_r;
    acc_nxt         = acc_r;
    rsh_nxt         = rsh_r;
    qsel_nxt        = qsel_r;
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    rem_nxt         = rem_r;
    prog_nxt        = prog_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_elapsed_nxt = out_elapsed_r;
    out_prog_nxt    = out_prog_r;
    out_run_nxt     = out_run_r;
    out_stop_nxt    = out_stop_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          stop_nxt  = 1'b0;
          state_nxt = S_PROG;
          unique case (in_if.func)
            FUNC_ADVANCE: begin
              if (running_r) begin
                t_nxt     = rev_r ? (elapsed_w - value_w) : (elapsed_w + value_w);
                state_nxt = S_FIT;
              end
            end
            FUNC_SET_TIME: begin
              t_nxt     = value_w;
              state_nxt = S_FIT;
            end
            FUNC_SET_PROG: begin
              // Floor split of the fraction: whole part and nonnegative rest.
              if (q_full > 32'sd2) begin
                qsel_nxt = Q_TWO;
              end else if (q_full < -32'sd1) begin
                qsel_nxt = Q_MINUS;
              end else if (q_full == 32'sd2) begin
                qsel_nxt = Q_TWO;
              end else if (q_full == 32'sd1) begin
                qsel_nxt = Q_ONE;
              end else if (q_full == 32'sd0) begin
                qsel_nxt = Q_ZERO;
              end else begin
                qsel_nxt = Q_MINUS;
              end
              rsh_nxt   = in_if.value[FRAC_BITS-1:0];
              acc_nxt   = '0;
              cnt_nxt   = CNT_BITS'(FRAC_BITS - 1);
              state_nxt = S_MUL;
            end
            FUNC_START: begin
              elapsed_nxt = '0;
              running_nxt = 1'b1;
            end
            FUNC_STOP: begin
              running_nxt = 1'b0;
            end
            FUNC_RESUME: begin
              running_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_MUL: begin
        acc_nxt = mul_sum[TIME_BITS:1];
        rsh_nxt = rsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        t_nxt     = base_w + acc_w;
        state_nxt = S_FIT;
      end

      S_FIT: begin
        state_nxt = S_PROG;
        if (len_zero) begin
          elapsed_nxt = '0;
        end else if (t_r > len_w) begin
          if (loop_r) begin
            mag_nxt   = t_r[MAG_BITS-1:0];
            neg_nxt   = 1'b0;
            rem_nxt   = '0;
            cnt_nxt   = CNT_BITS'(MAG_BITS - 1);
            state_nxt = S_MOD;
          end else begin
            elapsed_nxt = len_r;
            stop_nxt    = 1'b1;
            running_nxt = 1'b0;
          end
        end else if (t_r[T_BITS-1]) begin
          if (loop_r) begin
            mag_nxt   = neg_t[MAG_BITS-1:0];
            neg_nxt   = 1'b1;
            rem_nxt   = '0;
            cnt_nxt   = CNT_BITS'(MAG_BITS - 1);
            state_nxt = S_MOD;
          end else begin
            elapsed_nxt = '0;
            stop_nxt    = 1'b1;
            running_nxt = 1'b0;
          end
        end else begin
          elapsed_nxt = t_r[TIME_BITS-1:0];
        end
      end

      S_MOD: begin
        rem_nxt = div_ge ? div_diff[TIME_BITS-1:0] : div_rem2[TIME_BITS-1:0];
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_WRAP;
        end
      end

      S_WRAP: begin
        // A negative time counts back from the end; an exact negative multiple gives L.
        elapsed_nxt = neg_r ? (len_r - rem_r) : rem_r;
        state_nxt   = S_PROG;
      end

      S_PROG: begin
        if (len_zero) begin
          prog_nxt  = '0;
          state_nxt = S_OUT;
        end else if (elapsed_r >= len_r) begin
          prog_nxt  = {1'b1, {FRAC_BITS{1'b0}}};
          state_nxt = S_OUT;
        end else begin
          rem_nxt   = elapsed_r;
          prog_nxt  = '0;
          cnt_nxt   = CNT_BITS'(FRAC_BITS - 1);
          state_nxt = S_PDIV;
        end
      end

      S_PDIV: begin
        rem_nxt  = div_ge ? div_diff[TIME_BITS-1:0] : div_rem2[TIME_BITS-1:0];
        prog_nxt = {prog_r[FRAC_BITS-1:0], div_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_elapsed_nxt = elapsed_r;
          out_prog_nxt    = prog_r;
          out_run_nxt     = running_r;
          out_stop_nxt    = stop_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      elapsed_r   <= '0;
      running_r   <= 1'b1;
      stop_r      <= 1'b0;
      len_r       <= '0;
      loop_r      <= 1'b0;
      rev_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      elapsed_r   <= elapsed_nxt;
      running_r   <= running_nxt;
      stop_r      <= stop_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LENGTH:  len_r  <= cfg_wdata;
          CFG_LOOP:    loop_r <= cfg_wdata[0];
          CFG_REVERSE: rev_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    t_r           <= t_nxt;
    acc_r         <= acc_nxt;
    rsh_r         <= rsh_nxt;
    qsel_r        <= qsel_nxt;
    mag_r         <= mag_nxt;
    neg_r         <= neg_nxt;
    rem_r         <= rem_nxt;
    prog_r        <= prog_nxt;
    out_elapsed_r <= out_elapsed_nxt;
    out_prog_r    <= out_prog_nxt;
    out_run_r     <= out_run_nxt;
    out_stop_r    <= out_stop_nxt;
  end

endmodule

/* dv/looping_elapsed_time_tracker_tb.sv */
// Self-checking testbench for the looping elapsed-time tracker.
module looping_elapsed_time_tracker_tb import lett_pkg::*; ();

  localparam int TIME_BITS       = 31;
  localparam int FRAC_BITS       = 16;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int STALL_LIMIT     = 3000;

  // Codes the block leaves unused; it must report the current state for them.
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {DRAIN_STEADY, DRAIN_LIGHT, DRAIN_HEAVY} drain_style_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] elapsed;
    logic [FRAC_BITS:0]   progress;
    logic                 running;
    logic                 stopped;
  } tracker_result_t;

  // Timeline state predicted from accepted requests, plus the results still owed.
  class timeline_checker;
    bit [TIME_BITS-1:0] length;
    bit                 loop_on;
    bit                 reverse_on;
    bit [TIME_BITS-1:0] elapsed;
    bit                 running;
    tracker_result_t    awaited_results[$];
    int                 mismatches;

    function new();
      running = 1'b1;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [TIME_BITS-1:0] data);
      case (idx)
        CFG_LENGTH:  length = data;
        CFG_LOOP:    loop_on = data[0];
        CFG_REVERSE: reverse_on = data[0];
        default: ;
      endcase
    endfunction

    // Wraps or clamps a new time into [0, length].
    function bit [TIME_BITS-1:0] fit_time(longint t, output bit clamped);
      longint len = length;
      clamped = 1'b0;
      if (len == 0) return '0;
      if (t > len) begin
        if (loop_on) return TIME_BITS'(t % len);
        clamped = 1'b1;
        return length;
      end
      if (t < 0) begin
        if (loop_on) return TIME_BITS'(len - ((-t) % len));
        clamped = 1'b1;
        return '0;
      end
      return TIME_BITS'(t);
    endfunction

    // Fraction of the length in fixed point, saturating at one.
    function bit [FRAC_BITS:0] progress_of(bit [TIME_BITS-1:0] e);
      longint len = length;
      if (len == 0) return '0;
      if (e >= len) return (FRAC_BITS+1)'(1) << FRAC_BITS;
      return (FRAC_BITS+1)'((longint'(e) << FRAC_BITS) / len);
    endfunction

    function void note_request(logic [FUNC_BITS-1:0] f, logic signed [VALUE_BITS-1:0] v);
      longint          sv = v;
      longint          t = 0;
      bit              apply = 1'b0;
      bit              clamped = 1'b0;
      tracker_result_t want;
      case (f)
        FUNC_ADVANCE: begin
          if (running) begin
            t = longint'(elapsed) + (reverse_on ? -sv : sv);
            apply = 1'b1;
          end
        end
        FUNC_SET_TIME: begin
          t = sv;
          apply = 1'b1;
        end
        FUNC_SET_PROG: begin
          // Exact product; the arithmetic shift floors toward minus infinity.
          t = (longint'(length) * sv) >>> FRAC_BITS;
          apply = 1'b1;
        end
        FUNC_START: begin
          elapsed = '0;
          running = 1'b1;
        end
        FUNC_STOP:   running = 1'b0;
        FUNC_RESUME: running = 1'b1;
        default: ;
      endcase
      if (apply) begin
        elapsed = fit_time(t, clamped);
        if (clamped) running = 1'b0;
      end
      want.elapsed  = elapsed;
      want.progress = progress_of(elapsed);
      want.running  = running;
      want.stopped  = clamped;
      awaited_results.push_back(want);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %0t %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(tracker_result_t got);
      tracker_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request outstanding", got.elapsed, 0);
      end else begin
        want = awaited_results.pop_front();
        if (got.elapsed !== want.elapsed)
          report_mismatch("elapsed_out", got.elapsed, want.elapsed);
        if (got.progress !== want.progress)
          report_mismatch("progress_out", got.progress, want.progress);
        if (got.running !== want.running)
          report_mismatch("running_out", got.running, want.running);
        if (got.stopped !== want.stopped)
          report_mismatch("stopped_now", got.stopped, want.stopped);
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [TIME_BITS-1:0]    cfg_wdata;

  timeline_checker tracker = new();
  drain_style_t    drain_style = DRAIN_STEADY;
  bit              hold_off_req = 1'b0;
  int              burst_left = 0;
  int              idle_cycles = 0;

  lett_in_if in_ch ();
  lett_out_if #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) out_ch ();

  looping_elapsed_time_tracker #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Offers one request and returns at the falling edge after it is taken.
  task automatic send_request(input logic [FUNC_BITS-1:0] f,
                              input logic signed [VALUE_BITS-1:0] v);
    in_ch.func  <= f;
    in_ch.value <= v;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_request(f, v);
    @(negedge clk);
  endtask

  task automatic idle_requests(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= $urandom();
      repeat (n) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every owed result has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (tracker.awaited_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_timeline(input bit [TIME_BITS-1:0] len, input bit loop_on,
                                  input bit reverse_on);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LENGTH;
    cfg_wdata <= len;
    tracker.write_register(CFG_LENGTH, len);
    @(negedge clk);
    cfg_index <= CFG_LOOP;
    cfg_wdata <= TIME_BITS'(loop_on);
    tracker.write_register(CFG_LOOP, TIME_BITS'(loop_on));
    @(negedge clk);
    cfg_index <= CFG_REVERSE;
    cfg_wdata <= TIME_BITS'(reverse_on);
    tracker.write_register(CFG_REVERSE, TIME_BITS'(reverse_on));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random requests in bursts; values are mostly scaled to the current length.
  task automatic run_random_requests(input int count);
    int                           r;
    longint                       span;
    logic [FUNC_BITS-1:0]         f;
    logic signed [VALUE_BITS-1:0] v;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) idle_requests(0);
        else if ($urandom_range(0, 4) == 0) idle_requests($urandom_range(20, 90));
        else idle_requests($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      r = $urandom_range(0, 99);
      if (r < 40) f = FUNC_ADVANCE;
      else if (r < 55) f = FUNC_SET_TIME;
      else if (r < 68) f = FUNC_SET_PROG;
      else if (r < 75) f = FUNC_START;
      else if (r < 82) f = FUNC_STOP;
      else if (r < 94) f = FUNC_RESUME;
      else f = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      span = (tracker.length == 0) ? 64 : tracker.length;
      case ($urandom_range(0, 9))
        0: v = $urandom();
        1: begin
          case ($urandom_range(0, 4))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 0;
            3: v = -1;
            default: v = 1;
          endcase
        end
        default: begin
          if (f == FUNC_SET_PROG) begin
            v = int'($urandom_range(0, 4 << FRAC_BITS)) - (1 << FRAC_BITS);
          end else if (span > 64'h1000_0000) begin
            v = $urandom();
          end else if (f == FUNC_ADVANCE) begin
            v = $urandom_range(0, span / 4 + 1);
            if ($urandom_range(0, 1)) v = -v;
          end else begin
            v = int'($urandom_range(0, 3 * span)) - int'(span);
          end
        end
      endcase
      send_request(f, v);
      burst_left--;
    end
  endtask

  // Result side: stall pattern by style, or a long hold-off when asked.
  initial begin
    bit seg_ready;
    int seg_left;
    seg_ready = 1'b1;
    seg_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          if (seg_ready && drain_style != DRAIN_STEADY) begin
            seg_ready = 1'b0;
            seg_left = (drain_style == DRAIN_LIGHT) ? $urandom_range(1, 3)
                                                    : $urandom_range(1, 20);
          end else begin
            seg_ready = 1'b1;
            seg_left = $urandom_range(1, 24);
          end
        end
        seg_left--;
        out_ch.ready <= seg_ready;
      end
    end
  end

  // Check each result when it is taken.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result('{out_ch.elapsed_out, out_ch.progress_out,
                             out_ch.running_out, out_ch.stopped_now});
  end

  // Watchdog on cycles in which neither side moves a request or a result.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    bit [TIME_BITS-1:0] len;
    in_ch.valid = 1'b0;
    in_ch.func  = FUNC_ADVANCE;
    in_ch.value = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_LENGTH;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Zero length out of reset: every new time collapses to zero.
    send_request(FUNC_SET_TIME, 5);
    send_request(FUNC_ADVANCE, 5);

    // Clamping: ends stop the timeline, even when it is already stopped.
    wait_drained();
    program_timeline(1000, 1'b0, 1'b0);
    send_request(FUNC_SET_TIME, 500);
    send_request(FUNC_ADVANCE, 32'h7FFF_FFFF);
    send_request(FUNC_ADVANCE, 5);
    send_request(FUNC_SET_TIME, 32'h8000_0000);
    send_request(FUNC_RESUME, 0);
    send_request(FUNC_SET_PROG, 32'h0000_8000);
    send_request(FUNC_SET_PROG, 32'h0001_0000);
    send_request(FUNC_SET_PROG, 32'h8000_0000);
    send_request(FUNC_START, 0);
    send_request(FUNC_STOP, 0);
    send_request(FUNC_SPARE_6, 32'h7FFF_FFFF);
    send_request(FUNC_SPARE_7, 32'h8000_0000);

    // Wrapping in reverse, including an exact negative multiple of the length.
    wait_drained();
    program_timeline(1000, 1'b1, 1'b1);
    send_request(FUNC_START, 0);
    send_request(FUNC_ADVANCE, 1000);
    send_request(FUNC_ADVANCE, 32'h8000_0000);
    send_request(FUNC_SET_TIME, -1);
    send_request(FUNC_SET_PROG, -65536);

    // Longest length, then a shorter one written below the elapsed time.
    wait_drained();
    program_timeline({TIME_BITS{1'b1}}, 1'b1, 1'b0);
    send_request(FUNC_SET_TIME, 32'h7FFF_FFFF);
    send_request(FUNC_ADVANCE, 1);
    send_request(FUNC_SET_PROG, 32'h0001_0000);
    wait_drained();
    program_timeline(1000, 1'b1, 1'b0);
    send_request(FUNC_STOP, 0);
    send_request(FUNC_ADVANCE, 7);
    send_request(FUNC_RESUME, 0);
    send_request(FUNC_ADVANCE, 1);

    // Random phases, each with fresh settings and its own stall style.
    for (int p = 0; p < 12; p++) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = {TIME_BITS{1'b1}};
        2, 3: len = $urandom_range(1, 16);
        4, 5, 6: len = $urandom_range(17, 5000);
        7, 8: len = $urandom_range(1, 1 << 20);
        default: len = $urandom();
      endcase
      program_timeline(len, $urandom_range(0, 1), $urandom_range(0, 1));
      drain_style = drain_style_t'($urandom_range(0, 2));
      if (p == 3) begin
        // The result side holds off while requests keep coming.
        run_random_requests(40);
        hold_off_req = 1'b1;
        run_random_requests(70);
      end else if (p == 6) begin
        run_random_requests(50);
        wait_drained();
        run_random_requests(60);
      end else begin
        run_random_requests(110);
      end
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (tracker.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
